// File: sv/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared constants, types and helpers of the barometric compensation core:
// field widths, pipeline stage numbers and the register map.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // default output scaling
  localparam int TEMP_FRAC_BITS_DEF  = 16;
  localparam int PRESS_FRAC_BITS_DEF = 8;

  // exact scaling of the internal temperature and pressure sums
  localparam int T_SCALE_BITS = 48;
  localparam int P_SCALE_BITS = 181;
  localparam int COEF_OFFSET  = 16384;

  // multiplier: 33x33 partial products summed by a registered binary tree
  localparam int MUL_PIECE_W     = 32;
  localparam int MUL_TREE_LEVELS = 4;
  localparam int MUL_LAT         = 1 + MUL_TREE_LEVELS;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [1:0] {
    REG_CAL_TEMP    = 2'd0,
    REG_CAL_PRESS_A = 2'd1,
    REG_CAL_PRESS_B = 2'd2,
    REG_CAL_PRESS_C = 2'd3
  } reg_idx_t;

  // datapath widths (signed)
  localparam int D_W    = 25;
  localparam int P_W    = 25;
  localparam int DT2_W  = 42;
  localparam int DD_W   = 50;
  localparam int DDT3_W = 58;
  localparam int NT_W   = 61;
  localparam int CT_W   = 69;
  localparam int PC11_W = 33;
  localparam int H1_W   = 70;
  localparam int H2_W   = 131;
  localparam int H3_W   = 192;
  localparam int E_W    = 194;
  localparam int PC_W   = 95;
  localparam int PE_W   = 219;
  localparam int ACC_W  = 220;

  // stage numbers, counted in clock edges after the input register
  localparam int ST_D   = 1;
  localparam int ST_M1  = ST_D + MUL_LAT;
  localparam int ST_M2  = ST_M1 + MUL_LAT;
  localparam int ST_NT  = ST_M2 + 1;
  localparam int ST_TQ  = ST_NT + 1;
  localparam int ST_M3  = ST_NT + MUL_LAT;
  localparam int ST_H1  = ST_M3 + 1;
  localparam int ST_M4  = ST_H1 + MUL_LAT;
  localparam int ST_H2  = ST_M4 + 1;
  localparam int ST_M5  = ST_H2 + MUL_LAT;
  localparam int ST_H3  = ST_M5 + 1;
  localparam int ST_E   = ST_H3 + 1;
  localparam int ST_M6  = ST_E + MUL_LAT;
  localparam int ST_ACC = ST_M6 + 1;
  localparam int ST_OUT = ST_ACC + 1;

  // edges from the accepting edge to the edge that takes the result word
  localparam int PIPE_LAT = ST_OUT + 1;

  // implemented bits of each register
  function automatic logic [CFG_DATA_W-1:0] reg_mask(input reg_idx_t idx);
    logic [CFG_DATA_W-1:0] m;
    case (idx)
      REG_CAL_TEMP:    m = {{(CFG_DATA_W-40){1'b0}}, {40{1'b1}}};
      REG_CAL_PRESS_A: m = {{(CFG_DATA_W-48){1'b0}}, {48{1'b1}}};
      REG_CAL_PRESS_B: m = {{(CFG_DATA_W-48){1'b0}}, {48{1'b1}}};
      REG_CAL_PRESS_C: m = {{(CFG_DATA_W-32){1'b0}}, {32{1'b1}}};
      default:         m = '0;
    endcase
    return m;
  endfunction

endpackage

// File: sv/barometric_pressure_compensation_core.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_core
// Turns a raw temperature and pressure sample pair into compensated
// temperature (degrees C) and pressure (pascal) using packed calibration
// coefficients held in four configuration registers.
//
// A sample pair is taken on every clock (busy is low once out of reset). Its
// result word appears on the out_ ports with out_valid for one cycle. The
// pipeline is six chained multiplier pipelines of five stages each
// (temperature, then the Horner steps of the pressure polynomial), plus
// the input, difference, adder and output registers. Results cannot be
// held off, so the receiver must take each word in the cycle it is shown.
// Calibration must be written over the APB-style port only while no sample
// is in flight; the core itself does not enforce this.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_core #(
  parameter int TEMP_FRAC_BITS  = bpc_pkg::TEMP_FRAC_BITS_DEF,
  parameter int PRESS_FRAC_BITS = bpc_pkg::PRESS_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // sample channel
  input  logic                            start,
  output logic                            busy,
  input  logic [23:0]                     in_raw_pressure,
  input  logic [23:0]                     in_raw_temperature,
  // result channel
  output logic                            out_valid,
  output logic signed [23:0]              out_temperature,
  output logic [24:0]                     out_pressure,
  output logic                            out_saturated,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bpc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [bpc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import bpc_pkg::*;

  localparam int TSH   = T_SCALE_BITS - TEMP_FRAC_BITS;
  localparam int PSH   = P_SCALE_BITS - PRESS_FRAC_BITS;
  localparam int TR_W  = NT_W + 1;
  localparam int L_NT  = ST_H2 - ST_NT;
  localparam int L_PC  = ST_H3 - ST_M4;
  localparam int L_TQ  = ST_ACC - ST_TQ;

  // --------------------------------------------------------------------------
  // configuration registers
  logic [39:0] cal_temp_r;
  logic [47:0] cal_press_a_r;
  logic [47:0] cal_press_b_r;
  logic [31:0] cal_press_c_r;
  reg_idx_t    cfg_idx;

  assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_temp_r    <= '0;
      cal_press_a_r <= '0;
      cal_press_b_r <= '0;
      cal_press_c_r <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (cfg_idx)
        REG_CAL_TEMP:    cal_temp_r    <= pwdata[39:0];
        REG_CAL_PRESS_A: cal_press_a_r <= pwdata[47:0];
        REG_CAL_PRESS_B: cal_press_b_r <= pwdata[47:0];
        REG_CAL_PRESS_C: cal_press_c_r <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (cfg_idx)
      REG_CAL_TEMP:    prdata = CFG_DATA_W'(cal_temp_r);
      REG_CAL_PRESS_A: prdata = CFG_DATA_W'(cal_press_a_r);
      REG_CAL_PRESS_B: prdata = CFG_DATA_W'(cal_press_b_r);
      REG_CAL_PRESS_C: prdata = CFG_DATA_W'(cal_press_c_r);
      default:         prdata = '0;
    endcase
  end

  // coefficient fields
  logic [15:0]        t1, t2, p5, p6;
  logic signed [7:0]  t3, p3, p4, p7, p8, p10, p11;
  logic signed [15:0] p1, p2, p9;
  logic signed [16:0] p1_off, p2_off;

  assign t1     = cal_temp_r[15:0];
  assign t2     = cal_temp_r[31:16];
  assign t3     = cal_temp_r[39:32];
  assign p1     = cal_press_a_r[15:0];
  assign p2     = cal_press_a_r[31:16];
  assign p3     = cal_press_a_r[39:32];
  assign p4     = cal_press_a_r[47:40];
  assign p5     = cal_press_b_r[15:0];
  assign p6     = cal_press_b_r[31:16];
  assign p7     = cal_press_b_r[39:32];
  assign p8     = cal_press_b_r[47:40];
  assign p9     = cal_press_c_r[15:0];
  assign p10    = cal_press_c_r[23:16];
  assign p11    = cal_press_c_r[31:24];
  assign p1_off = 17'(p1) - 17'(COEF_OFFSET);
  assign p2_off = 17'(p2) - 17'(COEF_OFFSET);

  // --------------------------------------------------------------------------
  // input register and valid line
  logic        busy_r;
  logic        vld_r [0:ST_OUT];
  logic [23:0] in_rp_r;
  logic [23:0] in_rt_r;

  assign busy = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      for (int k = 0; k <= ST_OUT; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      busy_r   <= 1'b0;
      vld_r[0] <= start && !busy_r;
      for (int k = 1; k <= ST_OUT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    in_rp_r <= in_raw_pressure;
    in_rt_r <= in_raw_temperature;
  end

  // raw pressure carried along for the three pressure products
  logic [23:0] rp_dly_r [1:ST_E];

  always_ff @(posedge clk) begin
    rp_dly_r[1] <= in_rp_r;
    for (int k = 2; k <= ST_E; k++) begin
      rp_dly_r[k] <= rp_dly_r[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // temperature: nt = d*T2*2^18 + d*d*T3
  logic signed [D_W-1:0]    d_r;
  logic signed [DT2_W-1:0]  dt2;
  logic signed [DD_W-1:0]   dd;
  logic signed [DDT3_W-1:0] ddt3;
  logic signed [DT2_W-1:0]  dt2_dly_r [1:MUL_LAT];
  logic signed [NT_W-1:0]   nt_r;

  always_ff @(posedge clk) begin
    d_r <= $signed({1'b0, in_rt_r}) - $signed({1'b0, t1, 8'b0});
  end

  bpc_mul #(.AW(D_W), .BW(17)) u_mul_dt2 (
    .clk (clk), .a (d_r), .b ($signed({1'b0, t2})), .p (dt2)
  );

  bpc_mul #(.AW(D_W), .BW(D_W)) u_mul_dd (
    .clk (clk), .a (d_r), .b (d_r), .p (dd)
  );

  bpc_mul #(.AW(DD_W), .BW(8)) u_mul_ddt3 (
    .clk (clk), .a (dd), .b (t3), .p (ddt3)
  );

  always_ff @(posedge clk) begin
    dt2_dly_r[1] <= dt2;
    for (int k = 2; k <= MUL_LAT; k++) begin
      dt2_dly_r[k] <= dt2_dly_r[k-1];
    end
    nt_r <= (NT_W'(dt2_dly_r[MUL_LAT]) <<< 18) + NT_W'(ddt3);
  end

  // exact temperature carried for the pressure Horner steps
  logic signed [NT_W-1:0] nt_dly_r [1:L_NT];

  always_ff @(posedge clk) begin
    nt_dly_r[1] <= nt_r;
    for (int k = 2; k <= L_NT; k++) begin
      nt_dly_r[k] <= nt_dly_r[k-1];
    end
  end

  // round half up and clamp the temperature word
  logic signed [TR_W-1:0] tr;
  logic                   tr_sat;
  logic [23:0]            tq_nxt;
  logic [24:0]            tq_dly_r [0:L_TQ];

  assign tr     = (TR_W'(nt_r) + (TR_W'(1) <<< (TSH - 1))) >>> TSH;
  assign tr_sat = !((&tr[TR_W-1:23]) || !(|tr[TR_W-1:23]));

  always_comb begin
    if (!tr_sat) begin
      tq_nxt = tr[23:0];
    end else if (tr[TR_W-1]) begin
      tq_nxt = 24'h800000;
    end else begin
      tq_nxt = 24'h7FFFFF;
    end
  end

  always_ff @(posedge clk) begin
    tq_dly_r[0] <= {tr_sat, tq_nxt};
    for (int k = 1; k <= L_TQ; k++) begin
      tq_dly_r[k] <= tq_dly_r[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // first Horner step of each pressure polynomial
  logic signed [CT_W-1:0]   p8t, p4t, p10t;
  logic signed [PC11_W-1:0] pp11;
  logic signed [H1_W-1:0]   a1_r, b1_r, c1_r;

  bpc_mul #(.AW(8), .BW(NT_W)) u_mul_p8t (
    .clk (clk), .a (p8), .b (nt_r), .p (p8t)
  );

  bpc_mul #(.AW(8), .BW(NT_W)) u_mul_p4t (
    .clk (clk), .a (p4), .b (nt_r), .p (p4t)
  );

  bpc_mul #(.AW(8), .BW(NT_W)) u_mul_p10t (
    .clk (clk), .a (p10), .b (nt_r), .p (p10t)
  );

  bpc_mul #(.AW(P_W), .BW(8)) u_mul_pp11 (
    .clk (clk), .a ($signed({1'b0, rp_dly_r[ST_NT]})), .b (p11), .p (pp11)
  );

  always_ff @(posedge clk) begin
    a1_r <= H1_W'(p8t) + (H1_W'(p7) <<< 55);
    b1_r <= H1_W'(p4t) + (H1_W'(p3) <<< 53);
    c1_r <= H1_W'(p10t) + (H1_W'(p9) <<< 48) + (H1_W'(pp11) <<< 31);
  end

  // second step; pressure times the squared-pressure factor
  logic signed [H2_W-1:0] a1t, b1t, a2_r, b2_r;
  logic signed [PC_W-1:0] pc;
  logic signed [PC_W-1:0] pc_dly_r [1:L_PC];

  bpc_mul #(.AW(H1_W), .BW(NT_W)) u_mul_a1t (
    .clk (clk), .a (a1_r), .b (nt_dly_r[ST_H1-ST_NT]), .p (a1t)
  );

  bpc_mul #(.AW(H1_W), .BW(NT_W)) u_mul_b1t (
    .clk (clk), .a (b1_r), .b (nt_dly_r[ST_H1-ST_NT]), .p (b1t)
  );

  bpc_mul #(.AW(P_W), .BW(H1_W)) u_mul_pc (
    .clk (clk), .a ($signed({1'b0, rp_dly_r[ST_H1]})), .b (c1_r), .p (pc)
  );

  always_ff @(posedge clk) begin
    a2_r <= a1t + (H2_W'($signed({1'b0, p6})) <<< 105);
    b2_r <= b1t + (H2_W'(p2_off) <<< 104);
    pc_dly_r[1] <= pc;
    for (int k = 2; k <= L_PC; k++) begin
      pc_dly_r[k] <= pc_dly_r[k-1];
    end
  end

  // third step: constant-in-pressure sum and linear-in-pressure factor
  logic signed [H3_W-1:0]  a2t, b2t;
  logic signed [ACC_W-1:0] aa_r;
  logic signed [E_W-1:0]   b3_r;

  bpc_mul #(.AW(H2_W), .BW(NT_W)) u_mul_a2t (
    .clk (clk), .a (a2_r), .b (nt_dly_r[L_NT]), .p (a2t)
  );

  bpc_mul #(.AW(H2_W), .BW(NT_W)) u_mul_b2t (
    .clk (clk), .a (b2_r), .b (nt_dly_r[L_NT]), .p (b2t)
  );

  always_ff @(posedge clk) begin
    aa_r <= (ACC_W'(a2t) <<< 22) + (ACC_W'($signed({1'b0, p5})) <<< 184);
    b3_r <= E_W'(b2t) + (E_W'(p1_off) <<< 161);
  end

  // fold in the higher pressure powers; rounding half added to the constant part
  logic signed [E_W-1:0]   e_r;
  logic signed [ACC_W-1:0] ah_r;
  logic signed [ACC_W-1:0] ah_dly_r [1:MUL_LAT];

  always_ff @(posedge clk) begin
    e_r  <= b3_r + (E_W'(pc_dly_r[L_PC]) <<< 85);
    ah_r <= aa_r + (ACC_W'(1) <<< (PSH - 1));
    ah_dly_r[1] <= ah_r;
    for (int k = 2; k <= MUL_LAT; k++) begin
      ah_dly_r[k] <= ah_dly_r[k-1];
    end
  end

  // final product and sum
  logic signed [PE_W-1:0]  pe;
  logic signed [ACC_W-1:0] acc_r;

  bpc_mul #(.AW(P_W), .BW(E_W)) u_mul_pe (
    .clk (clk), .a ($signed({1'b0, rp_dly_r[ST_E]})), .b (e_r), .p (pe)
  );

  always_ff @(posedge clk) begin
    acc_r <= ah_dly_r[MUL_LAT] + ACC_W'(pe);
  end

  // --------------------------------------------------------------------------
  // scale, clamp and register the result word
  logic signed [ACC_W-1:0] pq;
  logic                    p_neg, p_big;
  logic [24:0]             pq_nxt;
  logic                    out_valid_r, out_saturated_r;
  logic [23:0]             out_temperature_r;
  logic [24:0]             out_pressure_r;

  assign pq    = acc_r >>> PSH;
  assign p_neg = acc_r[ACC_W-1];
  assign p_big = |pq[ACC_W-1:25];

  always_comb begin
    if (p_neg) begin
      pq_nxt = '0;
    end else if (p_big) begin
      pq_nxt = '1;
    end else begin
      pq_nxt = pq[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[ST_ACC];
    end
  end

  always_ff @(posedge clk) begin
    out_temperature_r <= tq_dly_r[L_TQ][23:0];
    out_pressure_r    <= pq_nxt;
    out_saturated_r   <= tq_dly_r[L_TQ][24] || p_neg || p_big;
  end

  assign out_valid       = out_valid_r && vld_r[ST_OUT];
  assign out_temperature = out_temperature_r;
  assign out_pressure    = out_pressure_r;
  assign out_saturated   = out_saturated_r;

endmodule

// File: sv/bpc_mul.sv
// ----------------------------------------------------------------------------
// bpc_mul
// Pipelined signed multiplier. Operands are cut into 32-bit pieces, all
// piece products are formed in one stage and summed by a registered tree.
// ----------------------------------------------------------------------------
module bpc_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                    clk,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);
  import bpc_pkg::*;

  localparam int PW = AW + BW;
  localparam int NA = (AW + MUL_PIECE_W - 1) / MUL_PIECE_W;
  localparam int NB = (BW + MUL_PIECE_W - 1) / MUL_PIECE_W;
  localparam int NL = 2 ** MUL_TREE_LEVELS;

  logic signed [NA*MUL_PIECE_W-1:0] a_ext;
  logic signed [NB*MUL_PIECE_W-1:0] b_ext;
  logic signed [PW-1:0]             pp_nxt [NL];
  logic signed [PW-1:0]             node_r [1:2*NL-1];

  assign a_ext = (NA*MUL_PIECE_W)'(a);
  assign b_ext = (NB*MUL_PIECE_W)'(b);

  // piece products; only the top piece of each operand carries the sign
  always_comb begin
    logic signed [MUL_PIECE_W:0]     pa;
    logic signed [MUL_PIECE_W:0]     pb;
    logic signed [2*MUL_PIECE_W+1:0] prod;
    for (int i = 0; i < NL; i++) begin
      pp_nxt[i] = '0;
    end
    for (int ia = 0; ia < NA; ia++) begin
      for (int ib = 0; ib < NB; ib++) begin
        pa = (ia == NA - 1) ?
             {a_ext[MUL_PIECE_W*ia+MUL_PIECE_W-1], a_ext[MUL_PIECE_W*ia +: MUL_PIECE_W]} :
             {1'b0, a_ext[MUL_PIECE_W*ia +: MUL_PIECE_W]};
        pb = (ib == NB - 1) ?
             {b_ext[MUL_PIECE_W*ib+MUL_PIECE_W-1], b_ext[MUL_PIECE_W*ib +: MUL_PIECE_W]} :
             {1'b0, b_ext[MUL_PIECE_W*ib +: MUL_PIECE_W]};
        prod = pa * pb;
        pp_nxt[ia*NB+ib] = PW'(prod) <<< (MUL_PIECE_W * (ia + ib));
      end
    end
  end

  // leaves and registered adder tree, root at node 1
  always_ff @(posedge clk) begin
    for (int i = 0; i < NL; i++) begin
      node_r[NL+i] <= pp_nxt[i];
    end
    for (int n = 1; n < NL; n++) begin
      node_r[n] <= node_r[2*n] + node_r[2*n+1];
    end
  end

  assign p = node_r[1];

endmodule

// File: sv/bpc_checker.sv
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks of the compensation core: fixed latency, repeatable
// results, calibration read-back and readiness after reset.
// ----------------------------------------------------------------------------
module bpc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic [23:0]                     in_raw_pressure,
  input logic [23:0]                     in_raw_temperature,
  input logic                            out_valid,
  input logic signed [23:0]              out_temperature,
  input logic [24:0]                     out_pressure,
  input logic                            out_saturated,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [bpc_pkg::CFG_ADDR_W-1:0]  paddr,
  input logic [bpc_pkg::CFG_DATA_W-1:0]  pwdata,
  input logic [bpc_pkg::CFG_DATA_W-1:0]  prdata,
  input logic                            pready
);
  import bpc_pkg::*;

  // every result word comes from a sample taken a fixed time earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result word without matching sample");

  // equal back-to-back samples give equal result words
  a_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid) &&
     $past(in_raw_pressure, PIPE_LAT) == $past(in_raw_pressure, PIPE_LAT + 1) &&
     $past(in_raw_temperature, PIPE_LAT) == $past(in_raw_temperature, PIPE_LAT + 1))
    |-> (out_temperature == $past(out_temperature) &&
         out_pressure == $past(out_pressure) &&
         out_saturated == $past(out_saturated)))
    else $error("same sample pair gave different results");

  // a written register reads back with its implemented bits
  a_readback: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(psel && penable && pwrite && pready) &&
     paddr == $past(paddr))
    |-> prdata == ($past(pwdata) & reg_mask(reg_idx_t'(paddr[CFG_ADDR_W-1:3]))))
    else $error("calibration register read-back mismatch");

  // the pipeline never holds off samples once out of reset
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

endmodule

bind barometric_pressure_compensation_core bpc_checker u_bpc_checker (.*);

// File: verif/barometric_pressure_compensation_core_tb.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_core_tb
// Self-checking bench for the barometric compensation core. Calibration is
// loaded over the APB-style port while the pipeline is empty. Sample pairs
// are then streamed with random sender gaps. Each accepted pair is run through
// an exact wide-integer model of the polynomial. The model computes the
// rounded and saturated temperature, pressure and flag, and every result word
// is checked against the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module barometric_pressure_compensation_core_tb;
  import bpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 60;

  typedef logic signed [319:0] wide_t;

  typedef struct packed {
    logic signed [23:0] temperature;
    logic [24:0]        pressure;
    logic               saturated;
  } comp_word_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [23:0] in_raw_pressure;
  logic [23:0] in_raw_temperature;
  logic out_valid;
  logic signed [23:0] out_temperature;
  logic [24:0] out_pressure;
  logic out_saturated;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  // calibration copy, masked to implemented bits
  logic [63:0] cal_shadow [4];
  comp_word_t  pending_words [$];
  int          send_gap_pct;
  int          error_count;
  int          quiet_cycles;

  barometric_pressure_compensation_core uut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_raw_pressure(in_raw_pressure), .in_raw_temperature(in_raw_temperature),
    .out_valid(out_valid), .out_temperature(out_temperature),
    .out_pressure(out_pressure), .out_saturated(out_saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // exact compensation of one sample pair with the current calibration
  function automatic comp_word_t compensate(input logic [23:0] rp, input logic [23:0] rt);
    wide_t one, d, nt, nt2, nt3, p, p2, p3, acc, tq;
    wide_t t1, t2, t3, c1, c2, c3, c4, c5, c6, c7, c8, c9, c10, c11;
    comp_word_t r;
    one = 1;
    t1 = cal_shadow[REG_CAL_TEMP][15:0];
    t2 = cal_shadow[REG_CAL_TEMP][31:16];
    t3 = $signed(cal_shadow[REG_CAL_TEMP][39:32]);
    c1 = $signed(cal_shadow[REG_CAL_PRESS_A][15:0]);
    c2 = $signed(cal_shadow[REG_CAL_PRESS_A][31:16]);
    c3 = $signed(cal_shadow[REG_CAL_PRESS_A][39:32]);
    c4 = $signed(cal_shadow[REG_CAL_PRESS_A][47:40]);
    c5 = cal_shadow[REG_CAL_PRESS_B][15:0];
    c6 = cal_shadow[REG_CAL_PRESS_B][31:16];
    c7 = $signed(cal_shadow[REG_CAL_PRESS_B][39:32]);
    c8 = $signed(cal_shadow[REG_CAL_PRESS_B][47:40]);
    c9 = $signed(cal_shadow[REG_CAL_PRESS_C][15:0]);
    c10 = $signed(cal_shadow[REG_CAL_PRESS_C][23:16]);
    c11 = $signed(cal_shadow[REG_CAL_PRESS_C][31:24]);
    c1 = c1 - COEF_OFFSET;
    c2 = c2 - COEF_OFFSET;

    // temperature scaled by 2^48
    d = rt;
    d = d - (t1 <<< 8);
    nt = d * t2 * (one <<< 18) + d * d * t3;
    tq = (nt + (one <<< 31)) >>> 32;
    r.saturated = 1'b0;
    if (tq > 8388607) begin
      tq = 8388607;
      r.saturated = 1'b1;
    end
    if (tq < -8388608) begin
      tq = -8388608;
      r.saturated = 1'b1;
    end
    r.temperature = tq[23:0];

    // pressure scaled by 2^181, from the unrounded temperature
    nt2 = nt * nt;
    nt3 = nt2 * nt;
    p = rp;
    p2 = p * p;
    p3 = p2 * p;
    acc = (c5 <<< 184) + ((nt * c6) <<< 127) + ((nt2 * c7) <<< 77) + ((nt3 * c8) <<< 22)
        + ((p * c1) <<< 161) + ((p * nt * c2) <<< 104) + ((p * nt2 * c3) <<< 53)
        + (p * nt3 * c4)
        + ((p2 * c9) <<< 133) + ((p2 * nt * c10) <<< 85) + ((p3 * c11) <<< 116);
    acc = (acc + (one <<< 172)) >>> 173;
    if (acc < 0) begin
      r.pressure = '0;
      r.saturated = 1'b1;
    end else if (acc > 33554431) begin
      r.pressure = '1;
      r.saturated = 1'b1;
    end else begin
      r.pressure = acc[24:0];
    end
    return r;
  endfunction

  // check each result word against the oldest prediction
  always @(posedge clk) begin
    comp_word_t exp_w;
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word T=%0d P=%0d S=%0d", $time,
                 out_temperature, out_pressure, out_saturated);
        error_count++;
      end else begin
        exp_w = pending_words.pop_front();
        if (out_temperature !== exp_w.temperature) begin
          $display("%0t: temperature expected %0d actual %0d", $time,
                   exp_w.temperature, out_temperature);
          error_count++;
        end
        if (out_pressure !== exp_w.pressure) begin
          $display("%0t: pressure expected %0d actual %0d", $time,
                   exp_w.pressure, out_pressure);
          error_count++;
        end
        if (out_saturated !== exp_w.saturated) begin
          $display("%0t: saturated expected %0d actual %0d", $time,
                   exp_w.saturated, out_saturated);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // send one sample pair; returns just after the accepting edge
  task automatic send_sample(input logic [23:0] rp, input logic [23:0] rt);
    bit done;
    while ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_raw_pressure <= rp;
    in_raw_temperature <= rt;
    done = 0;
    while (!done) begin
      @(negedge clk);
      done = !busy;
      @(posedge clk);
    end
    pending_words.push_back(compensate(rp, rt));
  endtask

  // wait for the pipeline to empty, then let it settle
  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cal(input reg_idx_t idx, input logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'({idx, 3'b000});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cal_shadow[idx] = value & reg_mask(idx);
  endtask

  task automatic load_cal(input logic [63:0] ct, pa, pb, pc);
    drain_pipe();
    write_cal(REG_CAL_TEMP, ct);
    write_cal(REG_CAL_PRESS_A, pa);
    write_cal(REG_CAL_PRESS_B, pb);
    write_cal(REG_CAL_PRESS_C, pc);
  endtask

  // plausible factory calibration with random spread
  task automatic load_typical_cal();
    logic [63:0] ct, pa, pb, pc;
    ct = {24'd0, 8'($urandom_range(0, 255)), 16'($urandom_range(16000, 22000)),
          16'($urandom_range(20000, 30000))};
    pa = {16'd0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
    pb = {16'd0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
    pc = $urandom();
    ct[39:32] = $signed(ct[39:32]) >>> 4;
    pa[47:40] = $signed(pa[47:40]) >>> 3;
    pb[47:40] = $signed(pb[47:40]) >>> 3;
    pc[31:24] = $signed(pc[31:24]) >>> 2;
    load_cal(ct, pa, pb, pc);
  endtask

  // raw temperature close to the calibration offset most of the time
  function automatic logic [23:0] pick_raw_temp();
    int base;
    base = int'(cal_shadow[REG_CAL_TEMP][15:0]) * 256;
    if ($urandom_range(99) < 70)
      return 24'(base + $urandom_range(0, 600000) - 300000);
    return 24'($urandom());
  endfunction

  task automatic test_reset_cal();
    send_sample(24'h000000, 24'h000000);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h000000, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'h000000);
  endtask

  task automatic test_cal_extremes();
    load_cal('1, '1, '1, '1);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h000000, 24'h000000);
    send_sample(24'h800000, 24'h7FFFFF);
    load_cal(64'h7F_FFFF_FFFF, 64'h7F7F_7FFF_7FFF, 64'h7F7F_FFFF_FFFF, 64'h7F7F_7FFF);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h000000, 24'h000000);
    send_sample(24'h123456, 24'h654321);
    load_cal(64'h80_FFFF_0000, 64'h8080_8000_8000, 64'h8080_0000_0000, 64'h8080_8000);
    send_sample(24'hFFFFFF, 24'h000000);
    send_sample(24'h000000, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
  endtask

  task automatic test_typical();
    logic [23:0] t0;
    load_typical_cal();
    t0 = 24'(int'(cal_shadow[REG_CAL_TEMP][15:0]) * 256);
    send_sample(24'h6E0000, t0);
    send_sample(24'h6E0000, t0 + 24'd100000);
    send_sample(24'h6E0000, t0 - 24'd100000);
    send_sample(24'h000000, t0);
    send_sample(24'hFFFFFF, t0);
    send_sample(24'h555555, 24'hAAAAAA);
    send_sample(24'hAAAAAA, 24'h555555);
  endtask

  task automatic test_random_stream(input int gap_pct, input int count);
    send_gap_pct = gap_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 110 == 0) begin
        if ($urandom_range(3) == 0)
          load_cal({$urandom(), $urandom()}, {$urandom(), $urandom()},
                   {$urandom(), $urandom()}, {$urandom(), $urandom()});
        else
          load_typical_cal();
      end
      if ($urandom_range(9) == 0)
        send_sample(24'($urandom()), 24'($urandom()));
      else
        send_sample(24'($urandom_range(0, 16777215)), pick_raw_temp());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_raw_pressure = '0;
    in_raw_temperature = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    error_count = 0;
    quiet_cycles = 0;
    send_gap_pct = 0;
    for (int i = 0; i < 4; i++) cal_shadow[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_cal();
    test_cal_extremes();
    test_typical();
    test_random_stream(37, 330);
    test_random_stream(73, 330);
    test_random_stream(0, 340);
    drain_pipe();

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
